// ===== hdl/zrld_pkg.sv =====
// ----------------------------------------------------------------------------
// Zero run-length decoder package
// Shared types and constants for the zero run-length decoder core.
// ----------------------------------------------------------------------------
package zrld_pkg;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_CODE  = 4'b0001,
        PH_COUNT = 4'b0010,
        PH_LOW   = 4'b0100,
        PH_HIGH  = 4'b1000
    } phase_t;

    // Result kind
    typedef enum logic {
        KIND_LITERAL = 1'b0,
        KIND_RUN     = 1'b1
    } kind_t;

    // Register map: index is paddr[2]
    localparam int          PADDR_W         = 3;
    localparam logic        REG_TOTAL_BYTES = 1'b0;

endpackage

// ===== hdl/zero_run_length_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Zero run-length decoder core
// Expands a zero run-length coded byte stream into literal writes and
// zero-run reports at output byte positions.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one encoded byte per transaction on the s_ channel (s_in_byte).
//   Each byte yields zero or one result transaction on the m_ channel:
//   a literal (kind 0, value, run_length 1) or a zero run (kind 1, start
//   position, clipped run_length). Escape, second escape and low bytes of a
//   run sequence give no result; a long run of length zero gives none.
//   finished is set on the result that brings the position to total_bytes;
//   after that, input bytes are taken and dropped.
//   Program total_bytes over the APB port (address 0) while idle.
// Throughput:
//   One byte per cycle while m_ready lets the result register drain. A byte
//   is held in the input register and then decoded into the result register,
//   which drives m_. Each step is one subtract, compare and add on the
//   32-bit position register, which carries from byte to byte.
// Reset (aresetn low, synchronous): phase returns to code byte, position
//   and total_bytes clear, both channels go empty.
// Stall: while m_ready is low the result register holds; the input register
//   still takes one more byte, then s_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module zero_run_length_decoder_core
    import zrld_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Encoded byte input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    // Decoded result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [31:0]        m_position,
    output logic [7:0]         m_value,
    output logic [15:0]        m_run_length,
    output logic               m_finished
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [31:0] total_bytes_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_bytes_reg <= '0;
        end else if (cfg_wr && (paddr[2] == REG_TOTAL_BYTES)) begin
            total_bytes_reg <= pwdata;
        end
    end

    // Read back total_bytes at its address, zero elsewhere
    assign prdata = (paddr[2] == REG_TOTAL_BYTES) ? total_bytes_reg : 32'd0;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       step;

    // Decode the held byte when the result register is free or draining
    assign step    = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    phase_t      phase_reg,     phase_next;
    logic [31:0] position_reg,  position_next;
    logic [7:0]  low_count_reg, low_count_next;

    // Decode results for the held byte
    logic        emit;
    kind_t       res_kind;
    logic [7:0]  res_value;
    logic [15:0] res_len;
    logic        res_finished;

    logic        done;
    logic [31:0] remain;
    logic        is_run;
    logic [15:0] raw_len;
    logic        clip;

    // Decoding is over once the position reaches total_bytes
    assign done   = (position_reg >= total_bytes_reg);
    assign remain = total_bytes_reg - position_reg;
    assign clip   = ({16'd0, raw_len} > remain);

    always_comb begin
        phase_next     = phase_reg;
        position_next  = position_reg;
        low_count_next = low_count_reg;
        emit           = 1'b0;
        is_run         = 1'b0;
        raw_len        = 16'd0;
        res_kind       = KIND_LITERAL;
        res_value      = 8'd0;
        res_len        = 16'd1;
        res_finished   = 1'b0;

        if (!done) begin
            unique case (phase_reg)
                PH_CODE: begin
                    if (in_byte_reg == 8'd0) begin
                        phase_next = PH_COUNT;
                    end else begin
                        // Literal: write and advance by one
                        emit          = 1'b1;
                        res_value     = in_byte_reg;
                        position_next = position_reg + 32'd1;
                        res_finished  = (remain == 32'd1);
                    end
                end
                PH_COUNT: begin
                    if (in_byte_reg == 8'd0) begin
                        phase_next = PH_LOW;
                    end else begin
                        phase_next = PH_CODE;
                        is_run     = 1'b1;
                        raw_len    = {8'd0, in_byte_reg};
                    end
                end
                PH_LOW: begin
                    low_count_next = in_byte_reg;
                    phase_next     = PH_HIGH;
                end
                PH_HIGH: begin
                    phase_next = PH_CODE;
                    is_run     = 1'b1;
                    raw_len    = {in_byte_reg, low_count_reg};
                end
                default: begin
                    phase_next = PH_CODE;
                end
            endcase

            // Zero run: drop a zero length, clip to the bytes that remain
            if (is_run && (raw_len != 16'd0)) begin
                emit     = 1'b1;
                res_kind = KIND_RUN;
                if (clip) begin
                    res_len       = remain[15:0];
                    position_next = total_bytes_reg;
                    res_finished  = 1'b1;
                end else begin
                    res_len       = raw_len;
                    position_next = position_reg + {16'd0, raw_len};
                    res_finished  = (remain == {16'd0, raw_len});
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_CODE;
            position_reg  <= '0;
            low_count_reg <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            position_reg  <= position_next;
            low_count_reg <= low_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic        m_valid_reg;
    kind_t       m_kind_reg;
    logic [31:0] m_position_reg;
    logic [7:0]  m_value_reg;
    logic [15:0] m_run_length_reg;
    logic        m_finished_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load payload only on a new result; hold it while stalled
    always_ff @(posedge aclk) begin
        if (step && emit) begin
            m_kind_reg       <= res_kind;
            m_position_reg   <= position_reg;
            m_value_reg      <= res_value;
            m_run_length_reg <= res_len;
            m_finished_reg   <= res_finished;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_position   = m_position_reg;
    assign m_value      = m_value_reg;
    assign m_run_length = m_run_length_reg;
    assign m_finished   = m_finished_reg;

`ifndef NO_ASSERTIONS
    // A literal always reports length one and a nonzero value
    a_literal_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind_reg == KIND_LITERAL)) |-> (m_run_length == 16'd1) &&
        (m_value != 8'd0))
        else $error("literal result with bad length or value");

    // A run reports a zero value and a nonzero length
    a_run_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind_reg == KIND_RUN)) |-> (m_value == 8'd0) &&
        (m_run_length != 16'd0))
        else $error("run result with bad value or length");

    // Input stalls only while a byte is held behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid && !m_ready))
        else $error("input stalled without a blocked result");

    // Position advances exactly by the reported length of each result
    a_position_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && emit) |=> (position_reg ==
        ($past(position_reg) + {16'd0, m_run_length_reg})))
        else $error("position did not advance by the result length");

    // Nothing changes once decoding is done
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && done) |=> ($stable(position_reg) && $stable(phase_reg) &&
        !m_valid_reg))
        else $error("state changed after decoding finished");
`endif

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Zero run-length decoder core testbench
// Drives coded byte streams into the decoder and checks every literal write
// and zero-run report against a cycle-free model of the parser kept here,
// while both sides idle at random and total_bytes is reprogrammed over APB.
// ----------------------------------------------------------------------------
module testbench
    import zrld_pkg::*;
();

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 4;      // a byte passes the input register, then the result register, to m_*
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 480;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [7:0]         ESCAPE_BYTE      = 8'h00;
    localparam logic [PADDR_W-1:0] ADDR_TOTAL_BYTES = {REG_TOTAL_BYTES, 2'b00};
    // Next word up: no register lives there, so writes must be ignored
    localparam logic [PADDR_W-1:0] ADDR_SPARE       = {~REG_TOTAL_BYTES, 2'b00};

    // One decoded write, as the m_ channel reports it
    typedef struct packed {
        kind_t       kind;
        logic [31:0] position;
        logic [7:0]  value;
        logic [15:0] run_length;
        logic        finished;
    } decoded_write_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_in_byte = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic               m_kind;
    logic [31:0]        m_position;
    logic [7:0]         m_value;
    logic [15:0]        m_run_length;
    logic               m_finished;

    always #5 aclk = ~aclk;

    zero_run_length_decoder_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_position   (m_position),
        .m_value      (m_value),
        .m_run_length (m_run_length),
        .m_finished   (m_finished)
    );

    // ------------------------------------------------------------------------
    // Parser state as the testbench sees it, and the writes still owed
    // ------------------------------------------------------------------------
    logic [31:0]    total_cfg = '0;
    logic [31:0]    cur_pos   = '0;
    phase_t         cur_phase = PH_CODE;
    logic [7:0]     low_byte  = '0;
    decoded_write_t expected_writes[$];

    int  error_cnt     = 0;
    int  sent_cnt      = 0;
    int  decoded_cnt   = 0;
    int  dropped_cnt   = 0;
    int  literal_cnt   = 0;
    int  run_cnt       = 0;
    int  clipped_cnt   = 0;
    int  checked_cnt   = 0;
    int  finished_cnt  = 0;
    int  cycle_cnt     = 0;

    // Traffic shaping shared by sender and receiver
    bit  quiet         = 1'b0;   // no idle cycles on either side
    int  stall_req_cnt = 0;      // bump to ask the receiver for a long hold
    int  stall_seen    = 0;
    int  stall_left    = 0;
    int  ready_gap     = 0;

    // Mostly back-to-back, often a short gap, now and then a long gap
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Skip len zero positions, clipped to what is left before total_bytes
    task automatic emit_zero_run(input logic [31:0] len);
        decoded_write_t w;
        logic [31:0]    remain;
        remain = total_cfg - cur_pos;
        if (len == 0) return;
        if (len > remain) begin
            len = remain;
            clipped_cnt++;
        end
        w.kind       = KIND_RUN;
        w.position   = cur_pos;
        w.value      = 8'h00;
        w.run_length = len[15:0];
        cur_pos      = cur_pos + len;
        w.finished   = (cur_pos >= total_cfg);
        expected_writes.push_back(w);
        run_cnt++;
    endtask

    // Advance the parser by one accepted byte and queue any write it causes
    task automatic decode_byte(input logic [7:0] b);
        decoded_write_t w;
        // Past the end: drop the byte, keep the phase for a later raise
        if (cur_pos >= total_cfg) begin
            dropped_cnt++;
            return;
        end
        decoded_cnt++;
        case (cur_phase)
            PH_CODE: begin
                if (b == ESCAPE_BYTE) begin
                    cur_phase = PH_COUNT;
                end else begin
                    w.kind       = KIND_LITERAL;
                    w.position   = cur_pos;
                    w.value      = b;
                    w.run_length = 16'd1;
                    cur_pos      = cur_pos + 1;
                    w.finished   = (cur_pos >= total_cfg);
                    expected_writes.push_back(w);
                    literal_cnt++;
                end
            end
            PH_COUNT: begin
                // Second escape selects the long form with a 16-bit count
                if (b == ESCAPE_BYTE) begin
                    cur_phase = PH_LOW;
                end else begin
                    cur_phase = PH_CODE;
                    emit_zero_run({24'h0, b});
                end
            end
            PH_LOW: begin
                low_byte  = b;
                cur_phase = PH_HIGH;
            end
            default: begin
                cur_phase = PH_CODE;
                emit_zero_run({16'h0, b, low_byte});
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Input side: offer one byte, hold it until the transaction completes
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sent_cnt++;
        decode_byte(b);
        gap = quiet ? 0 : gap_len();
        // With no gap, leave valid high so the next byte follows directly
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid, wait for every owed write, then let the pipe empty out
    // (bytes that give no write may still be in flight)
    task automatic wait_decoder_idle();
        s_valid <= 1'b0;
        while (expected_writes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // APB: setup cycle, access cycle, then psel back low
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // The register takes the value at this edge
        if (addr[2] == REG_TOTAL_BYTES) total_cfg = data;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_total_readback();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TOTAL_BYTES;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (got !== total_cfg) begin
            error_cnt++;
            if (error_cnt <= MAX_REPORTS)
                $display("total_bytes readback: expected %08h, got %08h",
                         total_cfg, got);
        end
    endtask

    // One coded sequence with random content, now and then a broken one
    task automatic send_coded_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            send_byte(8'($urandom_range(1, 255)));
        end else if (r < 70) begin
            send_byte(ESCAPE_BYTE);
            send_byte(8'($urandom_range(1, 255)));
        end else if (r < 85) begin
            send_byte(ESCAPE_BYTE);
            send_byte(ESCAPE_BYTE);
            send_byte(8'($urandom_range(0, 255)));
            // Keep most long runs short so the position does not race ahead
            send_byte(8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 2)));
        end else if (r < 90) begin
            repeat (4) send_byte(ESCAPE_BYTE);
        end else begin
            // Noise: any bytes, which may leave a sequence half done
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // total_bytes resets to zero, so the decoder must drop everything
    task automatic test_total_zero();
        check_total_readback();
        send_byte(8'h01);
        send_byte(ESCAPE_BYTE);
        wait_decoder_idle();
    endtask

    // Literal extremes; the fourth one finishes, the fifth is dropped
    task automatic test_literals();
        apb_write(ADDR_TOTAL_BYTES, cur_pos + 4);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h55);
        wait_decoder_idle();
    endtask

    // Shortest short run, then the longest one clipped at the end
    task automatic test_short_runs();
        apb_write(ADDR_TOTAL_BYTES, cur_pos + 100);
        send_byte(ESCAPE_BYTE);
        send_byte(8'h01);
        send_byte(ESCAPE_BYTE);
        send_byte(8'hFF);
        wait_decoder_idle();
    endtask

    // Long form: length zero gives nothing, then 65535, then a clipped run
    task automatic test_long_runs();
        apb_write(ADDR_TOTAL_BYTES, cur_pos + 70000);
        repeat (4) send_byte(ESCAPE_BYTE);
        send_byte(ESCAPE_BYTE);
        send_byte(ESCAPE_BYTE);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(ESCAPE_BYTE);
        send_byte(ESCAPE_BYTE);
        send_byte(8'h34);
        send_byte(8'h12);
        wait_decoder_idle();
    endtask

    // Lower total_bytes inside a run sequence, then raise it and resume
    task automatic test_done_mid_sequence();
        apb_write(ADDR_TOTAL_BYTES, cur_pos + 10);
        send_byte(ESCAPE_BYTE);
        wait_decoder_idle();
        apb_write(ADDR_TOTAL_BYTES, cur_pos);
        send_byte(8'h05);
        wait_decoder_idle();
        apb_write(ADDR_TOTAL_BYTES, cur_pos + 10);
        send_byte(8'h03);
        wait_decoder_idle();
    endtask

    // Unmapped write is ignored; largest total_bytes reads back intact
    task automatic test_register_map();
        apb_write(ADDR_SPARE, $urandom());
        check_total_readback();
        apb_write(ADDR_TOTAL_BYTES, 32'hFFFF_FFFF);
        check_total_readback();
        repeat (4) send_coded_sequence();
        wait_decoder_idle();
    endtask

    // Receiver holds off for a long stretch while bytes keep coming, so the
    // decoder fills up and stalls its input; then pause until all are back
    task automatic test_backpressure();
        apb_write(ADDR_TOTAL_BYTES, cur_pos + 1000);
        quiet = 1'b1;
        stall_req_cnt++;
        repeat (40) send_byte(8'($urandom_range(1, 255)));
        quiet = 1'b0;
        wait_decoder_idle();
    endtask

    // Random streams, each under a fresh total_bytes: small ones to hit the
    // end often, larger ones for long streams, and the maximum now and then
    task automatic test_random_stream();
        int          start_cnt;
        int          r;
        logic [31:0] next_total;
        start_cnt = sent_cnt;
        while (sent_cnt - start_cnt < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 3)
                next_total = cur_pos + $urandom_range(1, 60);
            else if (r < 9)
                next_total = cur_pos + $urandom_range(100, 20000);
            else
                next_total = 32'hFFFF_FFFF;
            apb_write(ADDR_TOTAL_BYTES, next_total);
            quiet = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(8, 30)) send_coded_sequence();
            quiet = 1'b0;
            wait_decoder_idle();
            if ($urandom_range(0, 3) == 0) check_total_readback();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus a long hold on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_req_cnt != stall_seen) begin
            stall_seen = stall_req_cnt;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else if (ready_gap > 0) begin
            m_ready <= 1'b0;
            ready_gap--;
        end else begin
            m_ready <= 1'b1;
            ready_gap = gap_len();
        end
    end

    // Compare every completed result transaction with the oldest owed write
    always @(posedge aclk) begin : check_writes
        decoded_write_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_writes.size() == 0) begin
                error_cnt++;
                if (error_cnt <= MAX_REPORTS)
                    $display("unexpected write: kind=%0d pos=%0d value=%02h len=%0d fin=%0d",
                             m_kind, m_position, m_value, m_run_length, m_finished);
            end else begin
                w = expected_writes.pop_front();
                checked_cnt++;
                if (w.finished) finished_cnt++;
                if (m_kind !== w.kind || m_position !== w.position ||
                    m_value !== w.value || m_run_length !== w.run_length ||
                    m_finished !== w.finished) begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS) begin
                        $display("mismatch: exp kind=%0d pos=%0d value=%02h len=%0d fin=%0d",
                                 w.kind, w.position, w.value, w.run_length, w.finished);
                        $display("          got kind=%0d pos=%0d value=%02h len=%0d fin=%0d",
                                 m_kind, m_position, m_value, m_run_length, m_finished);
                    end
                end
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d writes still owed",
                     cycle_cnt, expected_writes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_total_zero();
        test_literals();
        test_short_runs();
        test_long_runs();
        test_done_mid_sequence();
        test_register_map();
        test_backpressure();
        test_random_stream();
        wait_decoder_idle();

        $display("Decoded %0d coded bytes and dropped %0d past the end of the output",
                 decoded_cnt, dropped_cnt);
        $display("Checked %0d writes: %0d literals, %0d zero runs (%0d clipped), %0d finishing",
                 checked_cnt, literal_cnt, run_cnt, clipped_cnt, finished_cnt);
        if (error_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== zero_run_length_decoder_core.f =====
hdl/zrld_pkg.sv
hdl/zero_run_length_decoder_core.sv
test/testbench.sv
